/* rtl/qji_pkg.sv */
package qji_pkg;

  // Q2.14 one, widened to the 17-bit weight format
  localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

  // register map: word index taken from paddr[2]
  localparam int unsigned  ADDR_W        = 3;
  localparam logic [0:0]   REG_THRESHOLD = 1'b0;
  localparam logic [31:0]  THRESH_RESET  = 32'd1;

  // quotient bits produced by the divider
  localparam int unsigned QBITS = 32;

  localparam logic [31:0] S32_MAX_U = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN_U = 32'h8000_0000;

  typedef logic signed [31:0] q16_t;

  // Jacobian entries leaving the front end
  typedef struct packed {
    logic vld;
    q16_t j00;
    q16_t j01;
    q16_t j10;
    q16_t j11;
  } jac_t;

  // one divider stage: four lanes (a, b, c, d) sharing one divisor
  typedef struct packed {
    logic              vld;
    logic              sing;
    logic [62:0]       dvs;
    logic [3:0][63:0]  rem;
    logic [3:0][31:0]  q;
    logic [3:0]        neg;
    logic [3:0]        ovf;
  } divst_t;

endpackage

/* rtl/qji_jac.sv */
module qji_jac (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [3:0][31:0]  node_x,
  input  logic [3:0][31:0]  node_y,
  input  logic [15:0]       xi,
  input  logic [15:0]       eta,
  output qji_pkg::jac_t     jac_o
);

  logic              v1_r, v2_r, v3_r;
  logic [3:0][16:0]  wl_r, wh_r, wl_nxt, wh_nxt;
  logic [3:0][32:0]  dl_r, dh_r, dl_nxt, dh_nxt;
  logic [3:0][49:0]  pl_r, ph_r, pl_nxt, ph_nxt;
  logic [3:0][31:0]  j_r, j_nxt;
  logic signed [16:0] em, ep, xm, xp;

  function automatic logic signed [32:0] diff33(input logic [31:0] a, input logic [31:0] b);
    diff33 = $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  // stage 1: shape-function weights and corner differences
  always_comb begin
    em = qji_pkg::ONE_Q14 - $signed({eta[15], eta});
    ep = qji_pkg::ONE_Q14 + $signed({eta[15], eta});
    xm = qji_pkg::ONE_Q14 - $signed({xi[15], xi});
    xp = qji_pkg::ONE_Q14 + $signed({xi[15], xi});
    wl_nxt[0] = em; wh_nxt[0] = ep;
    dl_nxt[0] = diff33(node_x[1], node_x[0]);
    dh_nxt[0] = diff33(node_x[2], node_x[3]);
    wl_nxt[1] = xm; wh_nxt[1] = xp;
    dl_nxt[1] = diff33(node_x[3], node_x[0]);
    dh_nxt[1] = diff33(node_x[2], node_x[1]);
    wl_nxt[2] = em; wh_nxt[2] = ep;
    dl_nxt[2] = diff33(node_y[1], node_y[0]);
    dh_nxt[2] = diff33(node_y[2], node_y[3]);
    wl_nxt[3] = xm; wh_nxt[3] = xp;
    dl_nxt[3] = diff33(node_y[3], node_y[0]);
    dh_nxt[3] = diff33(node_y[2], node_y[1]);
  end

  // stage 2: weight times difference, exact 50-bit products
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pl_nxt[k] = $signed({{33{wl_r[k][16]}}, wl_r[k]}) * $signed({{17{dl_r[k][32]}}, dl_r[k]});
      ph_nxt[k] = $signed({{33{wh_r[k][16]}}, wh_r[k]}) * $signed({{17{dh_r[k][32]}}, dh_r[k]});
    end
  end

  // stage 3: sum, round half up to Q16.16, saturate
  always_comb begin
    logic signed [50:0] s;
    logic [34:0]        r;
    for (int k = 0; k < 4; k++) begin
      s = $signed({pl_r[k][49], pl_r[k]}) + $signed({ph_r[k][49], ph_r[k]}) + 51'sd32768;
      r = s[50:16];
      if (r[34:31] == 4'b0000 || r[34:31] == 4'b1111) begin
        j_nxt[k] = r[31:0];
      end else begin
        j_nxt[k] = r[34] ? qji_pkg::S32_MIN_U : qji_pkg::S32_MAX_U;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wl_r <= wl_nxt;
      wh_r <= wh_nxt;
      dl_r <= dl_nxt;
      dh_r <= dh_nxt;
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
      j_r  <= j_nxt;
    end
  end

  assign jac_o.vld = v3_r;
  assign jac_o.j00 = j_r[0];
  assign jac_o.j01 = j_r[1];
  assign jac_o.j10 = j_r[2];
  assign jac_o.j11 = j_r[3];

endmodule

/* rtl/qji_det.sv */
module qji_det (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [31:0]      thresh,
  input  qji_pkg::jac_t    jac_i,
  output qji_pkg::divst_t  div_o
);

  qji_pkg::jac_t    s4_r, s5_r;
  logic             v6_r;
  logic [63:0]      p0_r, p1_r, det_r;
  logic [62:0]      mag_r, mag_nxt;
  logic             dneg_r;
  logic [3:0][31:0] absn_r, absn_nxt;
  logic [3:0]       nsgn_r, nsgn_nxt;
  qji_pkg::divst_t  out_r, out_nxt;
  logic [63:0]      det_nxt;

  // stage 6: determinant magnitude, numerator magnitudes and signs
  // lanes: a = j11, b = -j01, c = -j10, d = j00
  always_comb begin
    det_nxt  = det_r;
    mag_nxt  = det_r[63] ? 63'(64'd0 - det_r) : det_r[62:0];
    absn_nxt[0] = s5_r.j11[31] ? 32'd0 - s5_r.j11 : s5_r.j11;
    absn_nxt[1] = s5_r.j01[31] ? 32'd0 - s5_r.j01 : s5_r.j01;
    absn_nxt[2] = s5_r.j10[31] ? 32'd0 - s5_r.j10 : s5_r.j10;
    absn_nxt[3] = s5_r.j00[31] ? 32'd0 - s5_r.j00 : s5_r.j00;
    nsgn_nxt[0] = s5_r.j11[31];
    nsgn_nxt[1] = !s5_r.j01[31] && (s5_r.j01 != '0);
    nsgn_nxt[2] = !s5_r.j10[31] && (s5_r.j10 != '0);
    nsgn_nxt[3] = s5_r.j00[31];
  end

  // stage 7: threshold test and rounded dividends
  always_comb begin
    out_nxt.vld  = 1'b0;
    out_nxt.sing = (mag_r == '0) || (mag_r < {31'd0, thresh});
    out_nxt.dvs  = mag_r;
    out_nxt.q    = '0;
    out_nxt.ovf  = '0;
    for (int k = 0; k < 4; k++) begin
      out_nxt.rem[k] = {absn_r[k], 32'd0} + {2'b00, mag_r[62:1]};
      out_nxt.neg[k] = nsgn_r[k] ^ dneg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.vld  <= 1'b0;
      s5_r.vld  <= 1'b0;
      v6_r      <= 1'b0;
      out_r.vld <= 1'b0;
    end else if (adv) begin
      s4_r.vld  <= jac_i.vld;
      s5_r.vld  <= s4_r.vld;
      v6_r      <= s5_r.vld;
      out_r.vld <= v6_r;
    end
  end

  // stages 4 and 5: cross products, then their difference
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r.j00 <= jac_i.j00; s4_r.j01 <= jac_i.j01;
      s4_r.j10 <= jac_i.j10; s4_r.j11 <= jac_i.j11;
      p0_r <= $signed({{32{jac_i.j00[31]}}, jac_i.j00}) * $signed({{32{jac_i.j11[31]}}, jac_i.j11});
      p1_r <= $signed({{32{jac_i.j01[31]}}, jac_i.j01}) * $signed({{32{jac_i.j10[31]}}, jac_i.j10});
      s5_r.j00 <= s4_r.j00; s5_r.j01 <= s4_r.j01;
      s5_r.j10 <= s4_r.j10; s5_r.j11 <= s4_r.j11;
      det_r <= p0_r - p1_r;
      dneg_r <= det_nxt[63];
      mag_r  <= mag_nxt;
      absn_r <= absn_nxt;
      nsgn_r <= nsgn_nxt;
      out_r.sing <= out_nxt.sing;
      out_r.dvs  <= out_nxt.dvs;
      out_r.rem  <= out_nxt.rem;
      out_r.q    <= out_nxt.q;
      out_r.neg  <= out_nxt.neg;
      out_r.ovf  <= out_nxt.ovf;
    end
  end

  assign div_o = out_r;

endmodule

/* rtl/qji_div.sv */
module qji_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  qji_pkg::divst_t  div_i,
  output qji_pkg::divst_t  div_o
);

  localparam int unsigned NST = qji_pkg::QBITS + 1;

  qji_pkg::divst_t st_r   [NST];
  qji_pkg::divst_t st_nxt [NST];

  // stage 0: quotient overflow test (dividend >= divisor * 2^32)
  always_comb begin
    st_nxt[0] = div_i;
    for (int k = 0; k < 4; k++) begin
      st_nxt[0].ovf[k] = {32'd0, div_i.rem[k]} >= {1'b0, div_i.dvs, 32'd0};
    end
  end

  // one restoring step per stage, quotient bit 31 first
  for (genvar s = 1; s < NST; s++) begin : g_step
    localparam int unsigned K = qji_pkg::QBITS - s;
    always_comb begin
      logic [95:0] dsh;
      logic        ge;
      st_nxt[s] = st_r[s-1];
      dsh = {33'd0, st_r[s-1].dvs} << K;
      for (int k = 0; k < 4; k++) begin
        ge = {32'd0, st_r[s-1].rem[k]} >= dsh;
        st_nxt[s].q[k][K] = ge;
        if (ge) begin
          st_nxt[s].rem[k] = st_r[s-1].rem[k] - dsh[63:0];
        end
      end
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[s].vld <= 1'b0;
      end else if (adv) begin
        st_r[s].vld <= (s == 0) ? div_i.vld : st_r[(s == 0) ? 0 : s-1].vld;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[s].sing <= st_nxt[s].sing;
        st_r[s].dvs  <= st_nxt[s].dvs;
        st_r[s].rem  <= st_nxt[s].rem;
        st_r[s].q    <= st_nxt[s].q;
        st_r[s].neg  <= st_nxt[s].neg;
        st_r[s].ovf  <= st_nxt[s].ovf;
      end
    end
  end

  assign div_o = st_r[NST-1];

endmodule

/* rtl/quad4_jacobian_inverse.sv */
// Bilinear quadrilateral Jacobian, determinant and inverse.
// Input channel (in_valid/in_ready): four Q16.16 corners and a Q2.14
// reference point (xi, eta) per transaction. Output channel
// (out_valid/out_ready): |det| in Q31.32, the four Q16.16 inverse entries
// and a singular flag; exactly one result per input transaction, in order.
// Configuration: APB-style port, singular_threshold at byte address 0;
// write it only while the pipeline is empty.
// Depth: 41 register stages. Throughput: one transaction per cycle while
// out_ready does not hold a result at the output, since all stages
// advance together; the depth is set mostly by the 33-stage restoring
// divider (an overflow test, then one quotient bit per stage, four lanes
// sharing one divisor).
// Reset (rst_n low, synchronous): all valid bits clear, threshold returns
// to 1. When the receiver holds out_ready low with a result waiting, the
// whole pipeline freezes and in_ready drops; nothing is lost or repeated.
module quad4_jacobian_inverse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_node0_x,
  input  logic signed [31:0]          in_node0_y,
  input  logic signed [31:0]          in_node1_x,
  input  logic signed [31:0]          in_node1_y,
  input  logic signed [31:0]          in_node2_x,
  input  logic signed [31:0]          in_node2_y,
  input  logic signed [31:0]          in_node3_x,
  input  logic signed [31:0]          in_node3_y,
  input  logic signed [15:0]          in_ref_xi,
  input  logic signed [15:0]          in_ref_eta,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [62:0]                 out_det_magnitude,
  output logic signed [31:0]          out_inv_a,
  output logic signed [31:0]          out_inv_b,
  output logic signed [31:0]          out_inv_c,
  output logic signed [31:0]          out_inv_d,
  output logic                        out_singular,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [qji_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic             adv;
  logic [31:0]      thr_r;
  logic             out_vld_r;
  logic [62:0]      mag_r;
  logic [3:0][31:0] inv_r, inv_nxt;
  logic             sing_r;
  qji_pkg::jac_t    jac;
  qji_pkg::divst_t  dvi, dvo;

  // pipeline advances unless a result is stuck at the output
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == qji_pkg::REG_THRESHOLD) ? thr_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= qji_pkg::THRESH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == qji_pkg::REG_THRESHOLD) begin
      thr_r <= cfg_pwdata;
    end
  end

  qji_jac u_jac (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .node_x ({in_node3_x, in_node2_x, in_node1_x, in_node0_x}),
    .node_y ({in_node3_y, in_node2_y, in_node1_y, in_node0_y}),
    .xi     (in_ref_xi),
    .eta    (in_ref_eta),
    .jac_o  (jac)
  );

  qji_det u_det (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .thresh (thr_r),
    .jac_i  (jac),
    .div_o  (dvi)
  );

  qji_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .div_i  (dvi),
    .div_o  (dvo)
  );

  // final stage: apply sign, saturate, zero on singular
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dvo.sing) begin
        inv_nxt[k] = '0;
      end else if (dvo.neg[k]) begin
        if (dvo.ovf[k] || dvo.q[k] > qji_pkg::S32_MIN_U) begin
          inv_nxt[k] = qji_pkg::S32_MIN_U;
        end else begin
          inv_nxt[k] = 32'd0 - dvo.q[k];
        end
      end else begin
        if (dvo.ovf[k] || dvo.q[k][31]) begin
          inv_nxt[k] = qji_pkg::S32_MAX_U;
        end else begin
          inv_nxt[k] = dvo.q[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dvo.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r  <= dvo.dvs;
      inv_r  <= inv_nxt;
      sing_r <= dvo.sing;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_det_magnitude = mag_r;
  assign out_inv_a         = inv_r[0];
  assign out_inv_b         = inv_r[1];
  assign out_inv_c         = inv_r[2];
  assign out_inv_d         = inv_r[3];
  assign out_singular      = sing_r;

  // singular results carry a zero inverse
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> inv_r == '0)
    else $error("singular result with nonzero inverse");

  // a zero determinant is always flagged
  a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_det_magnitude == '0 |-> out_singular)
    else $error("zero determinant not flagged singular");

  // a regular result clears the threshold
  a_thresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_singular |-> out_det_magnitude >= {31'd0, thr_r})
    else $error("regular result below threshold");

endmodule
